FILE: rtl/hcb_pkg.sv
// hcb_pkg: types and constants for the huffman code builder
// no dependencies
`timescale 1ns / 1ps
package hcb_pkg;
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_SCAN_ISSUE,
    ST_SCAN_EVAL,
    ST_MERGE_A,
    ST_MERGE_B,
    ST_MERGE_NEW,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_EMIT
  } state_e;
endpackage

FILE: rtl/hcb_ram.sv
// hcb_ram: generic single-write, single-read ram with registered read
// no dependencies
`timescale 1ns / 1ps
module hcb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: rtl/huffman_code_builder.sv
// huffman_code_builder: top level, sequencer plus node table
// depends on hcb_pkg and hcb_ram
`timescale 1ns / 1ps
// Loads symbol_count weights, one request per cycle, into a node table. When the
// last weight is taken the block stalls its input and builds the tree: each of the
// n-1 merges scans every node made so far through one shared compare unit, node by
// node (ram read, then compare), keeping the two lightest parentless nodes in a
// single pass, then writes both children and the new node. Each symbol's path to
// the root is then walked level by level (ram read, then check), and its code
// request is held until the receiver takes it. Writing symbol_count restarts
// loading; write it only between builds.
module huffman_code_builder #(
  parameter int MAX_SYMBOLS = 64,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [6:0]             cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [WEIGHT_BITS-1:0] weight_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [5:0]             symbol_index_o,
  output logic [5:0]             code_length_o,
  output logic [62:0]            code_bits_o,
  output logic                   last_o
);
  localparam int Nodes = 2 * MAX_SYMBOLS - 1;
  localparam int Aw = $clog2(Nodes);
  localparam int Ww = WEIGHT_BITS + $clog2(MAX_SYMBOLS) + 1;
  localparam int Pw = Aw + 2 + Ww;

  hcb_pkg::state_e state_q, state_d;
  logic [6:0] count_q;
  logic [Aw:0] n, root;
  logic [Aw:0] loaded_q, loaded_d;
  logic [Aw:0] k_q, k_d;       // new node index
  logic [Aw:0] j_q, j_d;       // scan index
  logic [Aw-1:0] best_a_q, best_a_d, best_b_q, best_b_d;
  logic [Ww-1:0] wa_q, wa_d, wb_q, wb_d;
  logic ha_q, ha_d, hb_q, hb_d;
  logic [5:0] sym_q, sym_d, len_q, len_d;
  logic [62:0] bits_q, bits_d;
  logic [Aw-1:0] cur_q, cur_d;
  logic walk_end, last_sym;

  // node entry: {parent, right child flag, merged flag, weight}
  logic we;
  logic [Aw-1:0] waddr, raddr;
  logic [Pw-1:0] wdata, rdata;
  logic [Ww-1:0] r_w;
  logic r_merged, r_right;
  logic [Aw-1:0] r_par;

  hcb_ram #(.Width(Pw), .Depth(Nodes)) u_node (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign r_w = rdata[Ww-1:0];
  assign r_merged = rdata[Ww];
  assign r_right = rdata[Ww+1];
  assign r_par = rdata[Pw-1 -: Aw];

  always_comb begin
    if (count_q < 7'd2) n = (Aw+1)'(2);
    else if (count_q > 7'(MAX_SYMBOLS)) n = (Aw+1)'(MAX_SYMBOLS);
    else n = (Aw+1)'(count_q);
    root = (n << 1) - (Aw+1)'(2);
  end

  // walk ends when the current node is the root or the length cap hits
  assign walk_end = ((Aw+1)'(cur_q) == root) || (len_q == 6'd63);
  assign last_sym = ((Aw+1)'(sym_q) + (Aw+1)'(1) == n);

  always_comb begin
    state_d = state_q;
    case (state_q)
      hcb_pkg::ST_LOAD:
        if (in_valid_i && loaded_q == n - (Aw+1)'(1)) state_d = hcb_pkg::ST_INIT;
      hcb_pkg::ST_INIT: state_d = hcb_pkg::ST_SCAN_ISSUE;
      hcb_pkg::ST_SCAN_ISSUE: state_d = hcb_pkg::ST_SCAN_EVAL;
      hcb_pkg::ST_SCAN_EVAL:
        if (j_q + (Aw+1)'(1) == k_q) state_d = hcb_pkg::ST_MERGE_A;
        else state_d = hcb_pkg::ST_SCAN_ISSUE;
      hcb_pkg::ST_MERGE_A: state_d = hcb_pkg::ST_MERGE_B;
      hcb_pkg::ST_MERGE_B: state_d = hcb_pkg::ST_MERGE_NEW;
      hcb_pkg::ST_MERGE_NEW:
        if (k_q == root) state_d = hcb_pkg::ST_WALK_RD;
        else state_d = hcb_pkg::ST_SCAN_ISSUE;
      hcb_pkg::ST_WALK_RD:
        if (walk_end) state_d = hcb_pkg::ST_EMIT;
        else state_d = hcb_pkg::ST_WALK_CHK;
      hcb_pkg::ST_WALK_CHK: state_d = hcb_pkg::ST_WALK_RD;
      hcb_pkg::ST_EMIT:
        if (!out_stall_i) begin
          if (last_sym) state_d = hcb_pkg::ST_LOAD;
          else state_d = hcb_pkg::ST_WALK_RD;
        end
      default: state_d = hcb_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    we = 1'b0;
    waddr = '0; wdata = '0; raddr = '0;
    loaded_d = loaded_q; k_d = k_q; j_d = j_q;
    best_a_d = best_a_q; best_b_d = best_b_q; wa_d = wa_q; wb_d = wb_q;
    ha_d = ha_q; hb_d = hb_q;
    sym_d = sym_q; len_d = len_q; bits_d = bits_q; cur_d = cur_q;
    case (state_q)
      hcb_pkg::ST_LOAD: begin
        if (in_valid_i) begin
          we = 1'b1;
          waddr = loaded_q[Aw-1:0];
          wdata = {{(Pw-WEIGHT_BITS){1'b0}}, weight_i};
          loaded_d = loaded_q + (Aw+1)'(1);
        end
      end
      hcb_pkg::ST_INIT: begin
        loaded_d = '0;
        k_d = n; j_d = '0; ha_d = 1'b0; hb_d = 1'b0;
        sym_d = '0; cur_d = '0; len_d = '0; bits_d = '0;
      end
      hcb_pkg::ST_SCAN_ISSUE: raddr = j_q[Aw-1:0];
      hcb_pkg::ST_SCAN_EVAL: begin
        // single shared compare against the current two best
        if (!r_merged) begin
          if (!ha_q || r_w < wa_q) begin
            best_b_d = best_a_q; wb_d = wa_q; hb_d = ha_q;
            best_a_d = j_q[Aw-1:0]; wa_d = r_w; ha_d = 1'b1;
          end else if (!hb_q || r_w < wb_q) begin
            best_b_d = j_q[Aw-1:0]; wb_d = r_w; hb_d = 1'b1;
          end
        end
        j_d = j_q + (Aw+1)'(1);
      end
      hcb_pkg::ST_MERGE_A: begin
        we = 1'b1; waddr = best_a_q;
        wdata = {k_q[Aw-1:0], 1'b0, 1'b1, wa_q};
      end
      hcb_pkg::ST_MERGE_B: begin
        we = 1'b1; waddr = best_b_q;
        wdata = {k_q[Aw-1:0], 1'b1, 1'b1, wb_q};
      end
      hcb_pkg::ST_MERGE_NEW: begin
        we = 1'b1; waddr = k_q[Aw-1:0];
        wdata = {{(Aw+2){1'b0}}, wa_q + wb_q};
        k_d = k_q + (Aw+1)'(1);
        j_d = '0; ha_d = 1'b0; hb_d = 1'b0;
      end
      hcb_pkg::ST_WALK_RD: raddr = cur_q;
      hcb_pkg::ST_WALK_CHK: begin
        if (r_right) bits_d = bits_q | (63'd1 << len_q);
        len_d = len_q + 6'd1;
        cur_d = r_par;
      end
      hcb_pkg::ST_EMIT: begin
        if (!out_stall_i) begin
          sym_d = sym_q + 6'd1;
          cur_d = Aw'(sym_q) + Aw'(1);
          len_d = '0; bits_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hcb_pkg::ST_LOAD;
      count_q <= 7'd64;
      loaded_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
        loaded_q <= '0;
      end else loaded_q <= loaded_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d; j_q <= j_d;
    best_a_q <= best_a_d; best_b_q <= best_b_d;
    wa_q <= wa_d; wb_q <= wb_d; ha_q <= ha_d; hb_q <= hb_d;
    sym_q <= sym_d; len_q <= len_d; bits_q <= bits_d;
    cur_q <= cur_d;
  end

  assign in_stall_o = (state_q != hcb_pkg::ST_LOAD);
  assign out_valid_o = (state_q == hcb_pkg::ST_EMIT);
  assign symbol_index_o = sym_q;
  assign code_length_o = len_q;
  assign code_bits_o = bits_q;
  assign last_o = last_sym;
endmodule
